// ===== design/tofrcg_pkg.sv =====
// Package for the time-of-flight range confidence grader: types, constants, tables.
package tofrcg_pkg;

  localparam int unsigned NoisePoints = 10;
  localparam int unsigned NoiseIdxW   = 4;

  localparam logic [31:0] PeakLimit = 32'd2400;
  localparam logic [31:0] SnrLimit  = 32'd80;
  localparam logic [31:0] HighPeak  = 32'd8000000;
  localparam logic [31:0] MidPeak   = 32'd4000000;
  localparam logic [31:0] NearPeak  = 32'd800000;
  localparam logic [31:0] AllOnes   = 32'hFFFF_FFFF;

  localparam logic [2:0] RegPileupA = 3'd0;
  localparam logic [2:0] RegPileupB = 3'd1;
  localparam logic [2:0] RegPileupC = 3'd2;
  localparam logic [2:0] RegPileupD = 3'd3;
  localparam logic [2:0] RegOffset  = 3'd4;

  localparam logic [1:0] StatConfident = 2'd0;
  localparam logic [1:0] StatSemi      = 2'd1;
  localparam logic [1:0] StatNot       = 2'd2;

  typedef struct packed {
    logic signed [15:0] raw_distance;
    logic [31:0]        peak_main;
    logic [15:0]        noise_count;
    logic [31:0]        peak_ref;
    logic [23:0]        integration_count;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] distance_mm;
    logic [1:0]         range_status;
    logic [31:0]        peak_out;
    logic [15:0]        noise_out;
    logic [6:0]         confidence;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    OpLoad, OpRate, OpDen, OpQ, OpT, OpBias, OpP1r, OpNr, OpSeg,
    OpLow, OpUp, OpConf, OpSnr, OpFinish
  } op_e;

  typedef struct packed {
    logic load;
    logic issue;
    op_e  op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic seg_done;
  } dp_sts_t;

  function automatic logic [31:0] tab_noise(input logic [NoiseIdxW-1:0] i);
    logic [31:0] v;
    case (i)
      4'd0: v = 32'd19;    4'd1: v = 32'd83;    4'd2: v = 32'd163;
      4'd3: v = 32'd691;   4'd4: v = 32'd1243;  4'd5: v = 32'd2539;
      4'd6: v = 32'd5091;  4'd7: v = 32'd10395; 4'd8: v = 32'd20427;
      4'd9: v = 32'd33235;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] tab_lower(input logic [NoiseIdxW-1:0] i);
    logic [31:0] v;
    case (i)
      4'd0: v = 32'd16;   4'd1: v = 32'd25;   4'd2: v = 32'd45;
      4'd3: v = 32'd145;  4'd4: v = 32'd258;  4'd5: v = 32'd501;
      4'd6: v = 32'd1004; 4'd7: v = 32'd1980; 4'd8: v = 32'd3804;
      4'd9: v = 32'd6063;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] tab_upper(input logic [NoiseIdxW-1:0] i);
    logic [31:0] v;
    case (i)
      4'd0: v = 32'd26;   4'd1: v = 32'd35;   4'd2: v = 32'd61;
      4'd3: v = 32'd173;  4'd4: v = 32'd303;  4'd5: v = 32'd574;
      4'd6: v = 32'd1148; 4'd7: v = 32'd2220; 4'd8: v = 32'd4230;
      4'd9: v = 32'd6705;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/tofrcg_div.sv =====
// Radix-2 restoring 32-bit unsigned divider, one quotient bit per cycle.
module tofrcg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [31:0] quo_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] trial;

  assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
      cnt_d = (den_i == '0) ? 6'd0 : 6'd32;
      if (den_i == '0) quo_d = tofrcg_pkg::AllOnes;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 6'd1;
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule

// ===== design/tofrcg_datapath.sv =====
// Datapath: config registers, working registers, shared divider and result assembly.
module tofrcg_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  tofrcg_pkg::cfg_wr_t   cfg_i,
  input  tofrcg_pkg::in_item_t  item_i,
  input  tofrcg_pkg::dp_cmd_t   cmd_i,
  output tofrcg_pkg::dp_sts_t   sts_o,
  output tofrcg_pkg::out_item_t result_o
);
  localparam int unsigned IdxW = tofrcg_pkg::NoiseIdxW;
  localparam logic [IdxW-1:0] LastSeg = IdxW'(tofrcg_pkg::NoisePoints - 2);

  logic [31:0] a_q, b_q, c_q, d_q;
  logic [15:0] off_q;
  tofrcg_pkg::in_item_t it_q;
  logic [31:0] rate_q, q_q, t_q, bias_q, p1r_q, nr_q, lo_q, up_q, conf_q, dist_q;
  logic [31:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic [tofrcg_pkg::NoiseIdxW-1:0] seg_q;
  logic        seg_done_q;

  logic        div_start, div_busy;
  logic [31:0] div_num, div_den, div_quo, quo_s;
  logic [31:0] dist_sum, lo_tab, up_tab, n0, n1, span, mag;
  logic [31:0] nr_diff;
  logic [1:0]  status;
  logic [31:0] conf_sat;

  tofrcg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  assign n0      = tofrcg_pkg::tab_noise(seg_q);
  assign n1      = tofrcg_pkg::tab_noise(seg_q + 1'b1);
  assign span    = n1 - n0;
  assign nr_diff = nr_q - n0;
  assign mag     = nr_diff[31] ? (32'd0 - nr_diff) : nr_diff;
  assign quo_s   = neg_q ? (32'd0 - div_quo) : div_quo;

  // operands of each division and the product into acc
  always_comb begin
    div_num = '0;
    div_den = '0;
    acc_d   = acc_q;
    neg_d   = neg_q;
    lo_tab  = tofrcg_pkg::tab_lower(seg_q + 1'b1) - tofrcg_pkg::tab_lower(seg_q);
    up_tab  = tofrcg_pkg::tab_upper(seg_q + 1'b1) - tofrcg_pkg::tab_upper(seg_q);
    case (cmd_i.op)
      tofrcg_pkg::OpRate: begin
        div_num = {it_q.peak_ref[27:0], 4'd0};
        div_den = {8'd0, it_q.integration_count};
      end
      tofrcg_pkg::OpDen: acc_d = rate_q * d_q;
      tofrcg_pkg::OpQ: begin
        div_num = a_q;
        div_den = b_q - acc_q;
      end
      tofrcg_pkg::OpBias: begin
        div_num = t_q[31] ? (32'd0 - t_q) : t_q;
        div_den = d_q[31] ? (32'd0 - d_q) : d_q;
        neg_d   = t_q[31] ^ d_q[31];
      end
      tofrcg_pkg::OpP1r: begin
        div_den = {8'd0, it_q.integration_count};
        if (it_q.peak_main > tofrcg_pkg::HighPeak)
          div_num = {it_q.peak_main[23:0], 8'd0};
        else if (it_q.peak_main > tofrcg_pkg::MidPeak)
          div_num = {it_q.peak_main[22:0], 9'd0};
        else
          div_num = {it_q.peak_main[21:0], 10'd0};
        neg_d = 1'b0;
      end
      tofrcg_pkg::OpNr: begin
        div_num = {it_q.noise_count, 16'd0};
        div_den = {8'd0, it_q.integration_count};
      end
      tofrcg_pkg::OpLow: begin
        acc_d   = lo_tab * mag;
      end
      tofrcg_pkg::OpUp: begin
        div_num = acc_q;
        div_den = span;
        acc_d   = up_tab * mag;
      end
      tofrcg_pkg::OpConf: begin
        div_num = acc_q;
        div_den = span;
      end
      tofrcg_pkg::OpSnr: begin
        div_num = 32'd100 * (p1r_q - lo_q);
        div_den = up_q - lo_q;
      end
      tofrcg_pkg::OpFinish: begin
        div_num = it_q.peak_main;
        div_den = {16'd0, it_q.noise_count};
      end
      default: ;
    endcase
  end

  assign div_start = cmd_i.issue;
  assign dist_sum = 32'(it_q.raw_distance) + {16'd0, bias_q[15:0]} - {16'd0, off_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
      d_q <= 32'd1;
      off_q <= '0;
      seg_done_q <= 1'b0;
      seg_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_i.index)
          tofrcg_pkg::RegPileupA: a_q <= cfg_i.data;
          tofrcg_pkg::RegPileupB: b_q <= cfg_i.data;
          tofrcg_pkg::RegPileupC: c_q <= cfg_i.data;
          tofrcg_pkg::RegPileupD: d_q <= cfg_i.data;
          tofrcg_pkg::RegOffset:  off_q <= cfg_i.data[15:0];
          default: ;
        endcase
      end
      if (cmd_i.op == tofrcg_pkg::OpNr && !cmd_i.issue && !div_busy) begin
        seg_q <= '0;
        seg_done_q <= 1'b0;
      end else if (cmd_i.op == tofrcg_pkg::OpSeg && !seg_done_q) begin
        if (nr_q < n1 || seg_q == LastSeg) seg_done_q <= 1'b1;
        else seg_q <= seg_q + 1'b1;
      end
    end
  end

  // each op captures its own result while held with the divider idle
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    neg_q <= neg_d;
    if (cmd_i.load) it_q <= item_i;
    if (!cmd_i.issue && !div_busy) begin
      case (cmd_i.op)
        tofrcg_pkg::OpRate: rate_q <= div_quo;
        tofrcg_pkg::OpQ:    q_q <= div_quo;
        tofrcg_pkg::OpT:    t_q <= q_q - c_q;
        tofrcg_pkg::OpBias: begin
          bias_q <= (d_q == '0) ? 32'd0 : (quo_s[31] ? 32'd0 : quo_s);
        end
        tofrcg_pkg::OpP1r: begin
          if (it_q.peak_main > tofrcg_pkg::HighPeak) p1r_q <= {div_quo[29:0], 2'd0};
          else if (it_q.peak_main > tofrcg_pkg::MidPeak) p1r_q <= {div_quo[30:0], 1'b0};
          else p1r_q <= div_quo;
        end
        tofrcg_pkg::OpNr:   nr_q <= {div_quo[30:0], 1'b0};
        tofrcg_pkg::OpUp:   lo_q <= div_quo + tofrcg_pkg::tab_lower(seg_q);
        tofrcg_pkg::OpConf: up_q <= div_quo + tofrcg_pkg::tab_upper(seg_q);
        tofrcg_pkg::OpSnr: begin
          if (p1r_q < lo_q) conf_q <= 32'd0;
          else if (p1r_q > up_q) conf_q <= 32'd100;
          else conf_q <= div_quo;
        end
        tofrcg_pkg::OpFinish: dist_q <= dist_sum;
        default: ;
      endcase
    end
  end

  // final grading uses the peak-to-noise quotient of the last division directly from the divider
  logic [31:0] conf_f;
  always_comb begin
    conf_f = conf_q;
    if (it_q.peak_main < tofrcg_pkg::PeakLimit && div_quo < tofrcg_pkg::SnrLimit)
      conf_f = 32'd0;
    if (conf_f >= 32'd90) status = tofrcg_pkg::StatConfident;
    else if (conf_f >= 32'd30) status = tofrcg_pkg::StatSemi;
    else status = tofrcg_pkg::StatNot;
    if ((dist_q[15] || dist_q[15:0] < 16'd50) && it_q.peak_main < tofrcg_pkg::NearPeak)
      status = tofrcg_pkg::StatNot;
    conf_sat = (conf_f > 32'd100) ? 32'd100 : conf_f;
  end

  assign result_o.distance_mm  = dist_q[15:0];
  assign result_o.range_status = status;
  assign result_o.peak_out     = it_q.peak_main;
  assign result_o.noise_out    = it_q.noise_count;
  assign result_o.confidence   = conf_sat[6:0];

  assign sts_o.div_busy = div_busy;
  assign sts_o.seg_done = seg_done_q;
endmodule

// ===== design/tofrcg_ctrl.sv =====
// Controller: sequences the datapath operations for one frame.
module tofrcg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tofrcg_pkg::dp_sts_t sts_i,
  output tofrcg_pkg::dp_cmd_t cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  typedef enum logic [1:0] {StIdle, StIssue, StWait, StOut} state_e;

  state_e            state_q;
  tofrcg_pkg::op_e   op_q;
  logic              done_q;

  // ops that run a division; the others do not use the divider
  function automatic logic uses_div(input tofrcg_pkg::op_e op);
    return op == tofrcg_pkg::OpRate || op == tofrcg_pkg::OpQ ||
           op == tofrcg_pkg::OpBias || op == tofrcg_pkg::OpP1r ||
           op == tofrcg_pkg::OpNr   || op == tofrcg_pkg::OpUp  ||
           op == tofrcg_pkg::OpConf || op == tofrcg_pkg::OpSnr ||
           op == tofrcg_pkg::OpFinish;
  endfunction

  // each op issues its division, if any, and moves on once the divider is idle and any segment search is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q    <= tofrcg_pkg::OpLoad;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: if (start_i) begin
          op_q    <= tofrcg_pkg::OpRate;
          state_q <= StIssue;
        end
        StIssue: state_q <= StWait;
        StWait: if (!sts_i.div_busy &&
                    (op_q != tofrcg_pkg::OpSeg || sts_i.seg_done)) begin
          if (op_q == tofrcg_pkg::OpFinish) begin
            state_q <= StOut;
          end else begin
            op_q    <= tofrcg_pkg::op_e'(op_q + 1'b1);
            state_q <= StIssue;
          end
        end
        StOut: begin
          done_q  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o.load  = (state_q == StIdle) && start_i;
    cmd_o.op    = (state_q == StOut) ? tofrcg_pkg::OpLoad : op_q;
    cmd_o.issue = (state_q == StIssue) && uses_div(op_q);
    if (state_q == StWait || state_q == StIssue) cmd_o.op = op_q;
  end

  assign busy_o = (state_q != StIdle) || done_q;
  assign done_o = done_q;
endmodule

// ===== design/tof_range_confidence_grader_core.sv =====
// Top level of the time-of-flight range confidence grader.
// Each frame runs nine 32-bit divisions on one shared radix-2 divider, the operations
// without a division, a table segment search and an output state. A zero divisor ends
// its division early.
// The next start transfer is taken in the cycle after the strobe; busy is high until then.
// Result shown for one cycle on result_valid_o, receiver cannot stall; reset loads reg defaults.
module tof_range_confidence_grader_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  tofrcg_pkg::in_item_t  item_i,
  output logic                  result_valid_o,
  output tofrcg_pkg::out_item_t result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);
  tofrcg_pkg::dp_cmd_t cmd;
  tofrcg_pkg::dp_sts_t sts;
  tofrcg_pkg::cfg_wr_t cfg;
  logic                ctrl_busy;

  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;
  assign cfg_ready_o = 1'b1;
  assign busy        = ctrl_busy;

  tofrcg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start && !ctrl_busy),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (ctrl_busy),
    .done_o (result_valid_o)
  );

  tofrcg_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_we_i(cfg_valid_i),
    .cfg_i   (cfg),
    .item_i  (item_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .result_o(result_o)
  );
endmodule

// ===== design/tofrcg_checker.sv =====
// Port-level checker for the grader core and its bind.
module tofrcg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input tofrcg_pkg::out_item_t result_o
);
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("no busy after start");
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("strobe longer than one cycle");
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("strobe outside busy");
  a_conf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.confidence <= 7'd100) else $error("confidence above 100");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.range_status != 2'd3) else $error("bad status");
endmodule

bind tof_range_confidence_grader_core tofrcg_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .result_valid_o(result_valid_o), .result_o(result_o)
);
